// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Package of the text console writer: request and result types, command codes, constants.
package tcw_pkg;

  localparam int CmdW      = 2;
  localparam int CharW     = 8;
  localparam int ColorW    = 8;
  localparam int ReadRowW  = 5;
  localparam int ReadColW  = 7;
  localparam int CursRowW  = 5;
  localparam int CursColW  = 7;

  localparam logic [CmdW-1:0] CMD_PUT   = 2'd0;
  localparam logic [CmdW-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

  localparam logic [CharW-1:0]  NEWLINE_CODE = 8'd10;
  localparam logic [CharW-1:0]  SPACE_CODE   = 8'd32;
  localparam logic [ColorW-1:0] RESET_COLOR  = 8'd2;

  typedef struct packed {
    logic [CmdW-1:0]     cmd;
    logic [CharW-1:0]    char_code;
    logic [ReadRowW-1:0] read_row;
    logic [ReadColW-1:0] read_col;
  } in_req_t;

  typedef struct packed {
    logic [CharW-1:0]    cell_char;
    logic [ColorW-1:0]   cell_color;
    logic [CursRowW-1:0] cursor_row;
    logic [CursColW-1:0] cursor_col;
    logic                scrolled;
  } out_rsp_t;

  // One screen cell: attribute in the high byte, character in the low byte.
  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [CharW-1:0]  ch;
  } cell_t;

endpackage

// ===== rtl/tcw_screen_ram.sv =====
// Screen memory: one write port and one read port with registered read data.
module tcw_screen_ram #(
  parameter int DEPTH  = 3200,
  parameter int ADDR_W = 12
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  tcw_pkg::cell_t      wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output tcw_pkg::cell_t      rdata
);

  tcw_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/text_console_writer_unit.sv =====
// Top level of the text console writer: cursor, command sequencer and screen memory.
//
// Users read this first. A request is taken at a rising edge where start is high and busy
// is low; exactly one result follows, shown on out_rsp for a single cycle while out_valid
// is high, and the receiver cannot hold it off. A put of a character or a newline that
// does not scroll and an unused command give their result in the cycle right after the
// request. A read gives it after an S_RD_WAIT state, because the screen memory has a
// registered read port. A clear writes every cell once through the single write port.
// A put or newline that moves past the last row scrolls: each of the (ROWS-1)*COLUMNS
// upper cells is read and then rewritten, and the bottom row is filled with spaces. The
// sweep over the memory handles one cell per port access. After reset the block runs a
// clearing pass that writes a space in the reset color into every cell; busy is high
// during that pass, while writes of the color register are taken as usual. The color
// register should only be written while the block is idle. Cells are addressed as a row
// number above a column number padded to a power of two, so the memory holds
// ROWS * 2**ceil(log2(COLUMNS)) words of which only ROWS*COLUMNS are used.
module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tcw_pkg::in_req_t  in_req,
  output logic              out_valid,
  output tcw_pkg::out_rsp_t out_rsp,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int ADDR_W = RW + CW;
  localparam int DEPTH  = ROWS * (2 ** CW);

  localparam logic [CW-1:0] LastCol = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LastRow = RW'(ROWS - 1);
  // Last row that is rewritten from the row below it during a scroll.
  localparam logic [RW-1:0] LastMoveRow = RW'(ROWS - 2);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD_WAIT,
    S_SC_RD,
    S_SC_WR,
    S_FILL
  } state_t;

  state_t state_r;

  // Cursor, color register and the sweep counters shared by scroll, clear and init.
  logic [RW-1:0] cur_row_r;
  logic [CW-1:0] cur_col_r;
  logic [7:0]    text_color_r;
  logic [RW-1:0] cnt_row_r;
  logic [CW-1:0] cnt_col_r;

  // Result registers.
  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic [7:0]    out_color_r;
  logic          out_scrolled_r;
  logic          rd_ok_r;

  // Memory port.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  tcw_pkg::cell_t    ram_wdata;
  tcw_pkg::cell_t    ram_rdata;

  logic accept;
  logic is_newline;
  logic line_wrap;
  logic read_in_range;
  logic cnt_last_col;
  logic [RW-1:0] cnt_row_inc;

  assign accept        = start && (state_r == S_IDLE);
  assign is_newline    = (in_req.char_code == tcw_pkg::NEWLINE_CODE);
  // A newline, or a character written into the last column, moves to the next row.
  assign line_wrap     = is_newline || (cur_col_r == LastCol);
  assign read_in_range = (32'(in_req.read_row) < ROWS) && (32'(in_req.read_col) < COLUMNS);
  assign cnt_last_col  = (cnt_col_r == LastCol);
  assign cnt_row_inc   = cnt_row_r + RW'(1);

  // Memory port control. The read address follows the request while idle so that a read
  // command has its data in the cycle after it is taken.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {cnt_row_r, cnt_col_r};
    ram_wdata = '{color: text_color_r, ch: tcw_pkg::SPACE_CODE};
    ram_raddr = {RW'(in_req.read_row), CW'(in_req.read_col)};
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_req.cmd == tcw_pkg::CMD_PUT) && !is_newline) begin
          ram_we    = 1'b1;
          ram_waddr = {cur_row_r, cur_col_r};
          ram_wdata = '{color: text_color_r, ch: in_req.char_code};
        end
      end
      S_SC_RD: begin
        // Fetch the cell one row below the one being rewritten.
        ram_raddr = {cnt_row_inc, cnt_col_r};
      end
      S_SC_WR: begin
        // The moved character takes the current color.
        ram_we    = 1'b1;
        ram_wdata = '{color: text_color_r, ch: ram_rdata.ch};
      end
      S_FILL: begin
        ram_we = 1'b1;
      end
      S_INIT: begin
        // The clearing pass after reset always uses the reset color.
        ram_we    = 1'b1;
        ram_wdata = '{color: tcw_pkg::RESET_COLOR, ch: tcw_pkg::SPACE_CODE};
      end
      S_RD_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, cursor and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      cnt_row_r    <= '0;
      cnt_col_r    <= '0;
      text_color_r <= tcw_pkg::RESET_COLOR;
      out_valid_r  <= 1'b0;
      rd_ok_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        text_color_r <= cfg_wdata;
      end
      unique case (state_r)
        S_INIT: begin
          if (cnt_last_col) begin
            cnt_col_r <= '0;
            if (cnt_row_r == LastRow) begin
              cnt_row_r <= '0;
              state_r   <= S_IDLE;
            end else begin
              cnt_row_r <= cnt_row_inc;
            end
          end else begin
            cnt_col_r <= cnt_col_r + CW'(1);
          end
        end

        S_IDLE: begin
          if (accept) begin
            out_char_r     <= '0;
            out_color_r    <= '0;
            out_scrolled_r <= 1'b0;
            unique case (in_req.cmd)
              tcw_pkg::CMD_PUT: begin
                if (!line_wrap) begin
                  cur_col_r   <= cur_col_r + CW'(1);
                  out_valid_r <= 1'b1;
                end else if (cur_row_r == LastRow) begin
                  // Past the bottom: scroll, cursor ends at the start of the last row.
                  cur_col_r      <= '0;
                  cnt_row_r      <= '0;
                  cnt_col_r      <= '0;
                  out_scrolled_r <= 1'b1;
                  state_r        <= S_SC_RD;
                end else begin
                  cur_row_r   <= cur_row_r + RW'(1);
                  cur_col_r   <= '0;
                  out_valid_r <= 1'b1;
                end
              end
              tcw_pkg::CMD_CLEAR: begin
                cur_row_r <= '0;
                cur_col_r <= '0;
                cnt_row_r <= '0;
                cnt_col_r <= '0;
                state_r   <= S_FILL;
              end
              tcw_pkg::CMD_READ: begin
                rd_ok_r <= read_in_range;
                state_r <= S_RD_WAIT;
              end
              default: begin
                out_valid_r <= 1'b1;
              end
            endcase
          end
        end

        S_RD_WAIT: begin
          if (rd_ok_r) begin
            out_char_r  <= ram_rdata.ch;
            out_color_r <= ram_rdata.color;
          end
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end

        S_SC_RD: begin
          state_r <= S_SC_WR;
        end

        S_SC_WR: begin
          if (cnt_last_col) begin
            cnt_col_r <= '0;
            cnt_row_r <= cnt_row_inc;
            // After the last moved row the counters already point at the bottom row.
            state_r   <= (cnt_row_r == LastMoveRow) ? S_FILL : S_SC_RD;
          end else begin
            cnt_col_r <= cnt_col_r + CW'(1);
            state_r   <= S_SC_RD;
          end
        end

        S_FILL: begin
          if (cnt_last_col) begin
            cnt_col_r <= '0;
            if (cnt_row_r == LastRow) begin
              cnt_row_r   <= '0;
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              cnt_row_r <= cnt_row_inc;
            end
          end else begin
            cnt_col_r <= cnt_col_r + CW'(1);
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  tcw_screen_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_rsp.cell_char    = out_char_r;
  assign out_rsp.cell_color   = out_color_r;
  // The cursor registers hold still from the result until the next request is taken.
  assign out_rsp.cursor_row   = tcw_pkg::CursRowW'(cur_row_r);
  assign out_rsp.cursor_col   = tcw_pkg::CursColW'(cur_col_r);
  assign out_rsp.scrolled     = out_scrolled_r;

endmodule

// ===== rtl/tcw_checker.sv =====
// Port-level checker of the text console writer and its bind to the top level.
`include "assert_macros.svh"

module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input tcw_pkg::out_rsp_t out_rsp
);

  localparam logic [tcw_pkg::CursRowW-1:0] BottomRow = tcw_pkg::CursRowW'(ROWS - 1);

  logic taken;
  logic col_ok;
  logic scroll_shown;
  logic at_bottom_start;

  assign taken           = start && !busy;
  assign col_ok          = (32'(out_rsp.cursor_col) < COLUMNS);
  assign scroll_shown    = out_valid && out_rsp.scrolled;
  assign at_bottom_start = (out_rsp.cursor_col == '0) && (out_rsp.cursor_row == BottomRow);

  `TCW_ASSERT_NOW(a_col_in_range, out_valid, col_ok, "cursor column beyond line end")
  `TCW_ASSERT_NOW(a_scroll_cursor, scroll_shown, at_bottom_start, "scroll cursor misplaced")
  `TCW_ASSERT_NEXT(a_taken_progress, taken, busy || out_valid, "request not in progress")
  `TCW_ASSERT_NOW(a_result_has_cause, out_valid, $past(taken) || $past(busy), "stray result")

endmodule

bind text_console_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
